// ----- hdl/fhan_pkg.sv -----
// shared types and constants for the fhan control datapath
package fhan_pkg;

  // datapath widths, sized for the widest case over the fraction-bit range
  localparam int A_W    = 61;   // signed a0, y, a2 and blends
  localparam int D_W    = 56;   // d = r*h*h
  localparam int AY_W   = 56;   // |y|
  localparam int S_W    = 60;   // d + 8|y|
  localparam int N_W    = 116;  // d*(d + 8|y|)
  localparam int ROOT_W = 58;   // square root bits, one per cell
  localparam int REM_W  = 60;   // square root partial remainder
  localparam int QUO_W  = 32;   // quotient bits, one per cell
  localparam int NUM_W  = 88;   // r*|a|
  localparam int DREM_W = 56;   // division partial remainder
  localparam int RES_W  = 33;   // signed result before saturation

  // configuration register indexes
  localparam logic [0:0] CFG_SPEED = 1'b0;
  localparam logic [0:0] CFG_STEP  = 1'b1;

  // side payload that rides along the square root chain
  typedef struct packed {
    logic signed [A_W-1:0] a0;
    logic signed [A_W-1:0] ysum;
    logic                  ypos;
    logic                  yneg;
    logic                  lt;
    logic                  eq;
  } sq_side_t;

  // working data of one square root cell
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [N_W-1:0]    rad;
  } sq_data_t;

  // side payload that rides along the division chain
  typedef struct packed {
    logic alt;
    logic apos;
    logic aneg;
  } dv_side_t;

  // working data of one division cell
  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUO_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
  } dv_data_t;

endpackage

// ----- hdl/adrc_fhan_optimal_control.sv -----
// fhan time-optimal control: a fixed pipeline of 103 stages from start to out_valid
// out_valid pulses once for each accepted start, one beat per result
// throughput: one item per cycle, busy is low whenever reset is released
// the path runs through the 58-cell square root chain and the 32-cell division chain
// reset: synchronous active-low rst_n clears all valid bits and loads r=100.0, h=0.01
// the receiver cannot stall: each result is on the out_ ports for exactly one cycle
module adrc_fhan_optimal_control #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] in_error_value,
  input  logic signed [31:0] in_rate_value,
  output logic        out_valid,
  output logic signed [31:0] out_control_out,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int A_W    = fhan_pkg::A_W;
  localparam int D_W    = fhan_pkg::D_W;
  localparam int ROOT_W = fhan_pkg::ROOT_W;
  localparam int QUO_W  = fhan_pkg::QUO_W;
  localparam int M_SH   = FRAC_BITS - 8;
  localparam int X_SH   = 32 - FRAC_BITS;
  localparam int D_SH   = FRAC_BITS + 16;
  localparam int LAT    = 6 + ROOT_W + 6 + QUO_W + 1;

  // configuration registers and the derived d = r*h*h
  logic [31:0]  speed_r;
  logic [23:0]  step_r;
  logic [47:0]  hh_r;
  logic [55:0]  rp0_r;
  logic [55:0]  rp1_r;
  logic [79:0]  dsum;
  logic [D_W-1:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 32'd6553600;
      step_r  <= 24'd167772;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fhan_pkg::CFG_SPEED: speed_r <= cfg_data;
        fhan_pkg::CFG_STEP:  step_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign dsum = {rp1_r, 24'd0} + {24'd0, rp0_r};

  // d follows the registers through three stages
  always_ff @(posedge clk) begin
    hh_r  <= step_r * step_r;
    rp0_r <= speed_r * hh_r[23:0];
    rp1_r <= speed_r * hh_r[47:24];
    d_r   <= D_W'(dsum >> D_SH);
  end

  assign busy = !rst_n;

  // stage 1: capture x1 and |x2|*h
  logic        acc;
  logic [31:0] x2mag;
  logic        v1_r;
  logic signed [31:0] x1_r;
  logic        x2neg_r;
  logic [55:0] mxh_r;

  assign acc   = start && !busy;
  assign x2mag = in_rate_value[31] ? 32'(-in_rate_value) : 32'(in_rate_value);

  always_ff @(posedge clk) begin
    x1_r    <= in_error_value;
    x2neg_r <= in_rate_value[31];
    mxh_r   <= x2mag * step_r;
  end

  // stage 2: a0 = h*x2 and y = x1 + a0
  logic [55:0]           m2;
  logic signed [A_W-1:0] a0_nxt;
  logic signed [A_W-1:0] x1q;
  logic                  v2_r;
  logic signed [A_W-1:0] a0_2_r;
  logic signed [A_W-1:0] y_r;

  always_comb begin
    m2     = mxh_r >> M_SH;
    a0_nxt = x2neg_r ? -$signed(A_W'(m2)) : $signed(A_W'(m2));
    x1q    = A_W'(x1_r) <<< X_SH;
  end

  always_ff @(posedge clk) begin
    a0_2_r <= a0_nxt;
    y_r    <= x1q + a0_nxt;
  end

  // stage 3: |y|, sign of y and a0 + y
  logic signed [A_W-1:0] yabs;
  logic                  v3_r;
  logic [fhan_pkg::AY_W-1:0] ay_r;
  logic signed [A_W-1:0] a0_3_r;
  logic signed [A_W-1:0] ysum_3_r;
  logic                  ypos_3_r;
  logic                  yneg_3_r;

  assign yabs = y_r[A_W-1] ? -y_r : y_r;

  always_ff @(posedge clk) begin
    ay_r     <= yabs[fhan_pkg::AY_W-1:0];
    a0_3_r   <= a0_2_r;
    ysum_3_r <= a0_2_r + y_r;
    ypos_3_r <= !y_r[A_W-1] && (y_r != '0);
    yneg_3_r <= y_r[A_W-1];
  end

  // stage 4: s = d + 8|y| and region compares
  logic                   v4_r;
  logic [fhan_pkg::S_W-1:0] s_r;
  fhan_pkg::sq_side_t     side4_r;
  fhan_pkg::sq_side_t     side4_nxt;

  always_comb begin
    side4_nxt.a0   = a0_3_r;
    side4_nxt.ysum = ysum_3_r;
    side4_nxt.ypos = ypos_3_r;
    side4_nxt.yneg = yneg_3_r;
    side4_nxt.lt   = ay_r < d_r;
    side4_nxt.eq   = (ay_r == d_r) && (d_r != '0);
  end

  always_ff @(posedge clk) begin
    s_r     <= fhan_pkg::S_W'(d_r) + {1'b0, ay_r, 3'b000};
    side4_r <= side4_nxt;
  end

  // stage 5: partial products of d*s
  logic               v5_r;
  logic [57:0]        pll_r;
  logic [57:0]        plh_r;
  logic [57:0]        phl_r;
  logic [57:0]        phh_r;
  fhan_pkg::sq_side_t side5_r;

  always_ff @(posedge clk) begin
    pll_r   <= d_r[27:0]  * s_r[29:0];
    plh_r   <= d_r[27:0]  * s_r[59:30];
    phl_r   <= d_r[55:28] * s_r[29:0];
    phh_r   <= d_r[55:28] * s_r[59:30];
    side5_r <= side4_r;
  end

  // stage 6: sum into the radicand
  logic               v6_r;
  logic [fhan_pkg::N_W-1:0] n_r;
  fhan_pkg::sq_side_t side6_r;

  always_ff @(posedge clk) begin
    n_r <= {58'd0, pll_r} + {28'd0, plh_r, 30'd0} + {30'd0, phl_r, 28'd0}
         + {phh_r, 58'd0};
    side6_r <= side5_r;
  end

  // front stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // square root chain
  logic               sq_vld  [ROOT_W+1];
  fhan_pkg::sq_data_t sq_data [ROOT_W+1];
  fhan_pkg::sq_side_t sq_side [ROOT_W+1];

  assign sq_vld[0]       = v6_r;
  assign sq_data[0].rem  = '0;
  assign sq_data[0].root = '0;
  assign sq_data[0].rad  = n_r;
  assign sq_side[0]      = side6_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sq
    fhan_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[i]),
      .in_data  (sq_data[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_data (sq_data[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // post 1: half = (a1 - d) / 2
  logic [ROOT_W-1:0]  a1d;
  logic               p1_v_r;
  logic [ROOT_W-2:0]  half_r;
  fhan_pkg::sq_side_t p1_side_r;

  assign a1d = sq_data[ROOT_W].root - ROOT_W'(d_r);

  always_ff @(posedge clk) begin
    half_r    <= a1d[ROOT_W-1:1];
    p1_side_r <= sq_side[ROOT_W];
  end

  // post 2: a2 = a0 + sign(y)*half
  logic signed [A_W-1:0] halfs;
  logic signed [A_W-1:0] a2_nxt;
  logic                  p2_v_r;
  logic signed [A_W-1:0] a2_r;
  fhan_pkg::sq_side_t    p2_side_r;

  always_comb begin
    halfs = $signed(A_W'(half_r));
    if (p1_side_r.ypos) begin
      a2_nxt = p1_side_r.a0 + halfs;
    end else if (p1_side_r.yneg) begin
      a2_nxt = p1_side_r.a0 - halfs;
    end else begin
      a2_nxt = p1_side_r.a0;
    end
  end

  always_ff @(posedge clk) begin
    a2_r      <= a2_nxt;
    p2_side_r <= p1_side_r;
  end

  // post 3: region blend, boundary mean truncated toward zero
  logic signed [A_W-1:0] tsum;
  logic signed [A_W-1:0] tmean;
  logic signed [A_W-1:0] a_nxt;
  logic                  p3_v_r;
  logic signed [A_W-1:0] a_r;

  always_comb begin
    tsum  = p2_side_r.ysum + a2_r;
    tmean = (tsum + $signed(A_W'(tsum[A_W-1]))) >>> 1;
    if (p2_side_r.lt) begin
      a_nxt = p2_side_r.ysum;
    end else if (p2_side_r.eq) begin
      a_nxt = tmean;
    end else begin
      a_nxt = a2_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

  // post 4: |a| and sign of a
  logic                 p4_v_r;
  logic [A_W-1:0]       amag_r;
  logic                 apos_4_r;
  logic                 aneg_4_r;

  always_ff @(posedge clk) begin
    amag_r   <= a_r[A_W-1] ? A_W'(-a_r) : A_W'(a_r);
    apos_4_r <= !a_r[A_W-1] && (a_r != '0);
    aneg_4_r <= a_r[A_W-1];
  end

  // post 5: linear region compare and partial products of r*|a|
  logic               p5_v_r;
  logic [59:0]        q0_r;
  logic [59:0]        q1_r;
  fhan_pkg::dv_side_t p5_side_r;

  always_ff @(posedge clk) begin
    q0_r           <= speed_r * amag_r[27:0];
    q1_r           <= speed_r * amag_r[55:28];
    p5_side_r.alt  <= amag_r < A_W'(d_r);
    p5_side_r.apos <= apos_4_r;
    p5_side_r.aneg <= aneg_4_r;
  end

  // post 6: numerator r*|a|
  logic                         p6_v_r;
  logic [fhan_pkg::NUM_W-1:0]   num_r;
  fhan_pkg::dv_side_t           p6_side_r;

  always_ff @(posedge clk) begin
    num_r     <= {28'd0, q0_r} + {q1_r, 28'd0};
    p6_side_r <= p5_side_r;
  end

  // post stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
    end else begin
      p1_v_r <= sq_vld[ROOT_W];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
    end
  end

  // division chain
  logic               dv_vld  [QUO_W+1];
  fhan_pkg::dv_data_t dv_data [QUO_W+1];
  fhan_pkg::dv_side_t dv_side [QUO_W+1];

  assign dv_vld[0]      = p6_v_r;
  assign dv_data[0].rem = num_r[fhan_pkg::NUM_W-1:QUO_W];
  assign dv_data[0].num = num_r[QUO_W-1:0];
  assign dv_data[0].quo = '0;
  assign dv_side[0]     = p6_side_r;

  for (genvar j = 0; j < QUO_W; j++) begin : g_dv
    fhan_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (d_r),
      .in_vld   (dv_vld[j]),
      .in_data  (dv_data[j]),
      .in_side  (dv_side[j]),
      .out_vld  (dv_vld[j+1]),
      .out_data (dv_data[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // output: apply sign, saturate, drive the result beat
  logic signed [fhan_pkg::RES_W-1:0] qs;
  logic signed [fhan_pkg::RES_W-1:0] rs;
  logic signed [fhan_pkg::RES_W-1:0] res;
  logic                              sat_hi;
  logic                              sat_lo;
  logic                              out_valid_r;
  logic signed [31:0]                out_control_r;
  logic                              out_sat_r;

  always_comb begin
    qs = $signed({1'b0, dv_data[QUO_W].quo});
    rs = $signed({1'b0, speed_r});
    if (dv_side[QUO_W].alt) begin
      res = dv_side[QUO_W].apos ? -qs : qs;
    end else if (dv_side[QUO_W].apos) begin
      res = -rs;
    end else if (dv_side[QUO_W].aneg) begin
      res = rs;
    end else begin
      res = '0;
    end
    sat_hi = res > $signed(fhan_pkg::RES_W'(32'h7fff_ffff));
    sat_lo = res < -$signed(fhan_pkg::RES_W'(33'h0_8000_0000));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (sat_hi) begin
      out_control_r <= 32'sh7fff_ffff;
    end else if (sat_lo) begin
      out_control_r <= 32'sh8000_0000;
    end else begin
      out_control_r <= res[31:0];
    end
    out_sat_r <= sat_hi || sat_lo;
  end

  assign out_valid       = out_valid_r;
  assign out_control_out = out_control_r;
  assign out_saturated   = out_sat_r;

  // checks
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result beat missing after fixed latency");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching start");

  a_root_ge_d: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld[ROOT_W] |-> (sq_data[ROOT_W].root >= ROOT_W'(d_r)))
    else $error("square root below d");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_control_out == 32'sh7fff_ffff || out_control_out == 32'sh8000_0000))
    else $error("saturation flag without a rail value");

endmodule

// ----- hdl/fhan_sqrt_cell.sv -----
// one restoring square root cell, resolves one root bit per beat
module fhan_sqrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  fhan_pkg::sq_data_t  in_data,
  input  fhan_pkg::sq_side_t  in_side,
  output logic                out_vld,
  output fhan_pkg::sq_data_t  out_data,
  output fhan_pkg::sq_side_t  out_side
);

  logic [fhan_pkg::REM_W+1:0] rem_sh;
  logic [fhan_pkg::REM_W+1:0] trial;
  logic [fhan_pkg::REM_W+1:0] diff;
  logic                       ge;
  fhan_pkg::sq_data_t         data_nxt;
  logic                       vld_r;
  fhan_pkg::sq_data_t         data_r;
  fhan_pkg::sq_side_t         side_r;

  // bring down two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {in_data.rem, in_data.rad[fhan_pkg::N_W-1 -: 2]};
    trial  = {2'b00, in_data.root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
    data_nxt.rem  = ge ? diff[fhan_pkg::REM_W-1:0] : rem_sh[fhan_pkg::REM_W-1:0];
    data_nxt.root = {in_data.root[fhan_pkg::ROOT_W-2:0], ge};
    data_nxt.rad  = {in_data.rad[fhan_pkg::N_W-3:0], 2'b00};
  end

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;
  assign out_side = side_r;

endmodule

// ----- hdl/fhan_div_cell.sv -----
// one restoring division cell, resolves one quotient bit per beat
module fhan_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fhan_pkg::D_W-1:0]    divisor,
  input  logic                        in_vld,
  input  fhan_pkg::dv_data_t          in_data,
  input  fhan_pkg::dv_side_t          in_side,
  output logic                        out_vld,
  output fhan_pkg::dv_data_t          out_data,
  output fhan_pkg::dv_side_t          out_side
);

  logic [fhan_pkg::DREM_W:0] rem_sh;
  logic [fhan_pkg::DREM_W:0] diff;
  logic                      ge;
  fhan_pkg::dv_data_t        data_nxt;
  logic                      vld_r;
  fhan_pkg::dv_data_t        data_r;
  fhan_pkg::dv_side_t        side_r;

  // shift in the next numerator bit and subtract the divisor if it fits
  always_comb begin
    rem_sh = {in_data.rem, in_data.num[fhan_pkg::QUO_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
    data_nxt.rem = ge ? diff[fhan_pkg::DREM_W-1:0] : rem_sh[fhan_pkg::DREM_W-1:0];
    data_nxt.num = {in_data.num[fhan_pkg::QUO_W-2:0], 1'b0};
    data_nxt.quo = {in_data.quo[fhan_pkg::QUO_W-2:0], ge};
  end

  // valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;
  assign out_side = side_r;

endmodule
